// ===== rtl/cir_pkg.sv =====
// ----------------------------------------------------------------------------
// cir_pkg - contact impulse resolver shared definitions
// body record, command and result types, codes and fixed point helpers
// ----------------------------------------------------------------------------
package cir_pkg;

	// operation codes
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_RESOLVE = 2'd2;

	// body field codes
	localparam logic [2:0] FLD_PX = 3'd0;
	localparam logic [2:0] FLD_PY = 3'd1;
	localparam logic [2:0] FLD_VX = 3'd2;
	localparam logic [2:0] FLD_VY = 3'd3;
	localparam logic [2:0] FLD_AX = 3'd4;
	localparam logic [2:0] FLD_AY = 3'd5;
	localparam logic [2:0] FLD_IM = 3'd6;

	// configuration register index
	localparam logic REG_TIME_STEP = 1'b0;

	localparam logic signed [67:0] MAX32 = 68'sd2147483647;
	localparam logic signed [67:0] MIN32 = -68'sd2147483648;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic        [30:0] im;
	} body_t;

	typedef struct packed {
		logic        [1:0]  op;
		logic               two;
		logic        [2:0]  fsel;
		logic signed [31:0] wval;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [31:0] pen;
		logic        [15:0] rest;
	} cmd_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] read_value;
		logic               moved;
		logic               impulsed;
	} res_t;

	// clamp to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > MAX32) begin
			r = 32'sh7FFFFFFF;
		end else if (v < MIN32) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// shift right, round to nearest, ties away from zero
	function automatic logic signed [67:0] rs(input logic signed [67:0] v,
			input int unsigned s);
		logic [67:0] m;
		logic [67:0] r;
		m = v[67] ? 68'(-v) : 68'(v);
		r = (m + (68'd1 << (s - 1))) >> s;
		return v[67] ? -$signed(r) : $signed(r);
	endfunction

endpackage

// ===== rtl/cir_mem.sv =====
// ----------------------------------------------------------------------------
// cir_mem - body table
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module cir_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  cir_pkg::body_t wdata,
	input  logic [AW-1:0]  raddr,
	output cir_pkg::body_t rdata
);
	import cir_pkg::*;

	body_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/cir_div.sv =====
// ----------------------------------------------------------------------------
// cir_div - fractional divider
// restoring divide of |num| << frac by den, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cir_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] num,
	input  logic        [31:0] den,
	output logic               done,
	output logic signed [67:0] quo
);
	import cir_pkg::*;

	localparam int DW = 33 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic [31:0]   den_q;
	logic [32:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic [33:0]   mag;
	logic [32:0]   rem_sh;
	logic          ge;
	logic [67:0]   q_ext;

	assign mag    = num[33] ? 34'(-num) : 34'(num);
	assign rem_sh = {rem_q[31:0], quo_q[DW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign q_ext  = 68'(quo_q);
	assign quo    = neg_q ? -$signed(q_ext) : $signed(q_ext);
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[33];
			den_q <= den;
			rem_q <= '0;
			quo_q <= {mag[32:0], {FRAC_BITS{1'b0}}};
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

endmodule

// ===== rtl/cir_core.sv =====
// ----------------------------------------------------------------------------
// cir_core - resolver sequencer
// read-modify-write of body records around a shared multiplier and divider
// ----------------------------------------------------------------------------
module cir_core #(
	parameter int DEPTH     = 256,
	parameter int IW        = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cir_pkg::cmd_t cmd,
	input  logic [IW-1:0] idx_a,
	input  logic [IW-1:0] idx_b,
	input  logic [30:0]   time_step,
	output logic          idle,
	output cir_pkg::res_t res,
	input  logic          res_ready
);
	import cir_pkg::*;

	localparam int unsigned FB = FRAC_BITS;

	localparam logic [5:0] ST_IDLE = 6'd0;
	localparam logic [5:0] ST_RDA  = 6'd1;
	localparam logic [5:0] ST_RDB  = 6'd2;
	localparam logic [5:0] ST_LDB  = 6'd3;
	localparam logic [5:0] ST_P1   = 6'd4;
	localparam logic [5:0] ST_P2   = 6'd5;
	localparam logic [5:0] ST_DX   = 6'd6;
	localparam logic [5:0] ST_DY   = 6'd7;
	localparam logic [5:0] ST_PAX  = 6'd8;
	localparam logic [5:0] ST_PAY  = 6'd9;
	localparam logic [5:0] ST_PBX  = 6'd10;
	localparam logic [5:0] ST_PBY  = 6'd11;
	localparam logic [5:0] ST_V0   = 6'd12;
	localparam logic [5:0] ST_V1   = 6'd13;
	localparam logic [5:0] ST_V2   = 6'd14;
	localparam logic [5:0] ST_V3   = 6'd15;
	localparam logic [5:0] ST_V4   = 6'd16;
	localparam logic [5:0] ST_V5   = 6'd17;
	localparam logic [5:0] ST_V6   = 6'd18;
	localparam logic [5:0] ST_V7   = 6'd19;
	localparam logic [5:0] ST_V8   = 6'd20;
	localparam logic [5:0] ST_V9   = 6'd21;
	localparam logic [5:0] ST_V10  = 6'd22;
	localparam logic [5:0] ST_DI   = 6'd23;
	localparam logic [5:0] ST_I1   = 6'd24;
	localparam logic [5:0] ST_I2   = 6'd25;
	localparam logic [5:0] ST_I3   = 6'd26;
	localparam logic [5:0] ST_VAX  = 6'd27;
	localparam logic [5:0] ST_VAY  = 6'd28;
	localparam logic [5:0] ST_VBX  = 6'd29;
	localparam logic [5:0] ST_VBY  = 6'd30;
	localparam logic [5:0] ST_WA   = 6'd31;
	localparam logic [5:0] ST_WB   = 6'd32;
	localparam logic [5:0] ST_DONE = 6'd33;

	logic [5:0]         state_q, state_d;
	cmd_t               cmd_q;
	logic [IW-1:0]      ia_q, ib_q;
	logic               alias_q;
	body_t              a_q, b_q;
	logic [30:0]        im1_q;
	logic [31:0]        total_q;
	logic               pos_ok_q, imp_ok_q;
	logic signed [67:0] prod_q, sum_q;
	logic signed [33:0] numx_q, numy_q;
	logic signed [31:0] mx_q, my_q, sep_q, target_q, accdot_q, accsep_q;
	logic signed [31:0] imp_q, ix_q, iy_q, rd_q;

	body_t              rdata, wdata, wr_body;
	logic               we;
	logic [IW-1:0]      waddr, raddr;
	logic signed [33:0] mul_a, mul_b;
	logic signed [33:0] rvx, rvy, rax, ray;
	logic signed [31:0] sep_c, tgt_c, delta_c, rd_c;
	logic [31:0]        tot_c;
	logic               div_start, div_done;
	logic signed [33:0] div_num;
	logic signed [67:0] div_quo;
	logic signed [67:0] upd;

	cir_mem #(.DEPTH(DEPTH), .AW(IW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	cir_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (total_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign idle           = state_q == ST_IDLE;
	assign res.valid      = state_q == ST_DONE;
	assign res.read_value = rd_q;
	assign res.moved      = pos_ok_q;
	assign res.impulsed   = imp_ok_q;

	assign raddr = (state_q == ST_RDB) ? ib_q : ia_q;
	assign rvx   = 34'(a_q.vx) - (cmd_q.two ? 34'(b_q.vx) : 34'sd0);
	assign rvy   = 34'(a_q.vy) - (cmd_q.two ? 34'(b_q.vy) : 34'sd0);
	assign rax   = 34'(a_q.ax) - (cmd_q.two ? 34'(b_q.ax) : 34'sd0);
	assign ray   = 34'(a_q.ay) - (cmd_q.two ? 34'(b_q.ay) : 34'sd0);
	assign sep_c = sat32(rs(sum_q + prod_q, 14));
	assign tot_c = 32'(a_q.im) + (cmd_q.two ? 32'(rdata.im) : 32'd0);
	assign upd   = rs(prod_q, FB);

	// target velocity with the acceleration term, then velocity change
	always_comb begin
		tgt_c = target_q;
		if (accsep_q[31]) begin
			tgt_c = sat32(68'(target_q) + rs(prod_q, 15));
			if (tgt_c[31]) begin
				tgt_c = '0;
			end
		end
		delta_c = sat32(68'(tgt_c) - 68'(sep_q));
	end

	// field write merge and field read select
	always_comb begin
		wr_body = rdata;
		rd_c    = '0;
		case (cmd_q.fsel)
			FLD_PX: begin
				wr_body.px = cmd_q.wval;
				rd_c       = rdata.px;
			end
			FLD_PY: begin
				wr_body.py = cmd_q.wval;
				rd_c       = rdata.py;
			end
			FLD_VX: begin
				wr_body.vx = cmd_q.wval;
				rd_c       = rdata.vx;
			end
			FLD_VY: begin
				wr_body.vy = cmd_q.wval;
				rd_c       = rdata.vy;
			end
			FLD_AX: begin
				wr_body.ax = cmd_q.wval;
				rd_c       = rdata.ax;
			end
			FLD_AY: begin
				wr_body.ay = cmd_q.wval;
				rd_c       = rdata.ay;
			end
			FLD_IM: begin
				wr_body.im = cmd_q.wval[31] ? 31'd0 : cmd_q.wval[30:0];
				rd_c       = 32'(rdata.im);
			end
			default: begin
				wr_body = rdata;
			end
		endcase
	end

	// memory write port
	always_comb begin
		we    = 1'b0;
		waddr = ia_q;
		wdata = a_q;
		case (state_q)
			ST_RDB: begin
				we    = cmd_q.op == OP_WRITE;
				wdata = wr_body;
			end
			ST_WA: begin
				we = 1'b1;
			end
			ST_WB: begin
				we    = 1'b1;
				waddr = ib_q;
				wdata = b_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_LDB: begin
				mul_a = 34'(cmd_q.nx);
				mul_b = 34'(cmd_q.pen);
			end
			ST_P1: begin
				mul_a = 34'(cmd_q.ny);
				mul_b = 34'(cmd_q.pen);
			end
			ST_DY: begin
				mul_a = 34'(mx_q);
				mul_b = 34'(a_q.im);
			end
			ST_PAX: begin
				mul_a = 34'(my_q);
				mul_b = 34'(a_q.im);
			end
			ST_PAY: begin
				mul_a = 34'(mx_q);
				mul_b = 34'(im1_q);
			end
			ST_PBX: begin
				mul_a = 34'(my_q);
				mul_b = 34'(im1_q);
			end
			ST_V0: begin
				mul_a = rvx;
				mul_b = 34'(cmd_q.nx);
			end
			ST_V1: begin
				mul_a = rvy;
				mul_b = 34'(cmd_q.ny);
			end
			ST_V3: begin
				mul_a = -34'(sep_q);
				mul_b = 34'(cmd_q.rest);
			end
			ST_V4: begin
				mul_a = rax;
				mul_b = 34'(cmd_q.nx);
			end
			ST_V5: begin
				mul_a = ray;
				mul_b = 34'(cmd_q.ny);
			end
			ST_V7: begin
				mul_a = 34'(accdot_q);
				mul_b = 34'(time_step);
			end
			ST_V9: begin
				mul_a = 34'(accsep_q);
				mul_b = 34'(cmd_q.rest);
			end
			ST_I1: begin
				mul_a = 34'(imp_q);
				mul_b = 34'(cmd_q.nx);
			end
			ST_I2: begin
				mul_a = 34'(imp_q);
				mul_b = 34'(cmd_q.ny);
			end
			ST_I3: begin
				mul_a = 34'(ix_q);
				mul_b = 34'(a_q.im);
			end
			ST_VAX: begin
				mul_a = 34'(iy_q);
				mul_b = 34'(a_q.im);
			end
			ST_VAY: begin
				mul_a = 34'(ix_q);
				mul_b = 34'(im1_q);
			end
			ST_VBX: begin
				mul_a = 34'(iy_q);
				mul_b = 34'(im1_q);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// divider launch
	always_comb begin
		div_start = 1'b0;
		div_num   = numx_q;
		case (state_q)
			ST_P2: begin
				div_start = pos_ok_q;
			end
			ST_DX: begin
				div_start = div_done;
				div_num   = numy_q;
			end
			ST_V10: begin
				div_start = 1'b1;
				div_num   = 34'(delta_c);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_RDA;
			ST_RDA:  state_d = ST_RDB;
			ST_RDB:  state_d = (cmd_q.op == OP_RESOLVE) ? ST_LDB : ST_DONE;
			ST_LDB:  state_d = ST_P1;
			ST_P1:   state_d = ST_P2;
			ST_P2:   state_d = pos_ok_q ? ST_DX : ST_V0;
			ST_DX:   if (div_done) state_d = ST_DY;
			ST_DY:   if (div_done) state_d = ST_PAX;
			ST_PAX:  state_d = ST_PAY;
			ST_PAY:  state_d = cmd_q.two ? ST_PBX : ST_V0;
			ST_PBX:  state_d = ST_PBY;
			ST_PBY:  state_d = ST_V0;
			ST_V0:   state_d = ST_V1;
			ST_V1:   state_d = ST_V2;
			ST_V2:   state_d = (!sep_c[31] && sep_c != 32'sd0) || total_q == 32'd0
					? ST_WA : ST_V3;
			ST_V3:   state_d = ST_V4;
			ST_V4:   state_d = ST_V5;
			ST_V5:   state_d = ST_V6;
			ST_V6:   state_d = ST_V7;
			ST_V7:   state_d = ST_V8;
			ST_V8:   state_d = ST_V9;
			ST_V9:   state_d = ST_V10;
			ST_V10:  state_d = ST_DI;
			ST_DI:   if (div_done) state_d = ST_I1;
			ST_I1:   state_d = ST_I2;
			ST_I2:   state_d = ST_I3;
			ST_I3:   state_d = ST_VAX;
			ST_VAX:  state_d = ST_VAY;
			ST_VAY:  state_d = cmd_q.two ? ST_VBX : ST_WA;
			ST_VBX:  state_d = ST_VBY;
			ST_VBY:  state_d = ST_WA;
			ST_WA:   state_d = cmd_q.two ? ST_WB : ST_DONE;
			ST_WB:   state_d = ST_DONE;
			ST_DONE: if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				cmd_q    <= cmd;
				ia_q     <= idx_a;
				ib_q     <= idx_b;
				alias_q  <= cmd.two && (idx_a == idx_b);
				rd_q     <= '0;
				pos_ok_q <= 1'b0;
				imp_ok_q <= 1'b0;
			end
			ST_RDB: begin
				a_q <= rdata;
				if (cmd_q.op == OP_READ) rd_q <= rd_c;
			end
			ST_LDB: begin
				b_q      <= rdata;
				im1_q    <= cmd_q.two ? rdata.im : 31'd0;
				total_q  <= tot_c;
				pos_ok_q <= !cmd_q.pen[31] && tot_c != 32'd0;
			end
			ST_P1: numx_q <= 34'(rs(prod_q, 14));
			ST_P2: numy_q <= 34'(rs(prod_q, 14));
			ST_DX: if (div_done) mx_q <= sat32(div_quo);
			ST_DY: if (div_done) my_q <= sat32(div_quo);
			// same body twice: the second update starts from the first's result
			ST_PAX: begin
				a_q.px <= sat32(68'(a_q.px) + upd);
				if (alias_q) b_q.px <= sat32(68'(a_q.px) + upd);
			end
			ST_PAY: begin
				a_q.py <= sat32(68'(a_q.py) + upd);
				if (alias_q) b_q.py <= sat32(68'(a_q.py) + upd);
			end
			ST_PBX: b_q.px <= sat32(68'(b_q.px) - upd);
			ST_PBY: b_q.py <= sat32(68'(b_q.py) - upd);
			ST_V1:  sum_q <= prod_q;
			ST_V2: begin
				sep_q    <= sep_c;
				imp_ok_q <= (sep_c[31] || sep_c == 32'sd0) && total_q != 32'd0;
			end
			ST_V4:  target_q <= sat32(rs(prod_q, 15));
			ST_V5:  sum_q <= prod_q;
			ST_V6:  accdot_q <= sat32(rs(sum_q + prod_q, 14));
			ST_V8:  accsep_q <= sat32(rs(prod_q, FB));
			ST_DI:  if (div_done) imp_q <= sat32(div_quo);
			ST_I2:  ix_q <= sat32(rs(prod_q, 14));
			ST_I3:  iy_q <= sat32(rs(prod_q, 14));
			ST_VAX: begin
				a_q.vx <= sat32(68'(a_q.vx) + upd);
				if (alias_q) b_q.vx <= sat32(68'(a_q.vx) + upd);
			end
			ST_VAY: begin
				a_q.vy <= sat32(68'(a_q.vy) + upd);
				if (alias_q) b_q.vy <= sat32(68'(a_q.vy) + upd);
			end
			ST_VBX: b_q.vx <= sat32(68'(b_q.vx) - upd);
			ST_VBY: b_q.vy <= sat32(68'(b_q.vy) - upd);
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

endmodule

// ===== rtl/contact_impulse_resolver_top.sv =====
// ----------------------------------------------------------------------------
// contact_impulse_resolver_top - 2D particle contact resolver
// body table with write, read and contact resolve operations
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              carries
// s_*       in         s_tvalid / s_tready    one operation beat
// m_*       out        m_tvalid / m_tready    one result beat per operation
// apb       in         psel/penable/pwrite    time_step register at 0x0
//
// write and read take the read states, then the hand-off to the output register
// a resolve also sequences the contact states and uses the bit-serial divider
// for the position x and position y quotients when the bodies are moved and for
// the impulse quotient when an impulse is applied
// no clearing pass: the body table holds garbage after reset until written
// the output register lets a new beat in while a result waits; the core
// holds its finished result when that register is full and not drained
//
module contact_impulse_resolver_top #(
	parameter int BODY_COUNT    = 256,
	parameter int FRACTION_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// operation beat
	input  logic         s_tvalid,
	output logic         s_tready,
	// [7:0] first_body_index, [15:8] second_body_index, [16] has_second_body,
	// [19:17] field_select, [51:20] write_value, [67:52] normal_x,
	// [83:68] normal_y, [115:84] penetration, [131:116] restitution
	input  logic [135:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]   s_tuser,
	// result beat
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] read_value, [32] bodies_moved, [33] impulse_applied
	output logic [39:0]  m_tdata,
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import cir_pkg::*;

	localparam int IW = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;

	logic [30:0]   time_step_q;
	logic          m_tvalid_q;
	logic [39:0]   m_tdata_q;
	cmd_t          cmd;
	res_t          res;
	logic          idle;
	logic          res_ready;
	logic [IW-1:0] idx_a, idx_b;

	// index wraps modulo the table depth: binary long-division remainder
	function automatic logic [IW-1:0] wrap_idx(input logic [7:0] v);
		logic [24:0] r;
		logic [24:0] d;
		r = 25'(v);
		for (int k = 7; k >= 0; k--) begin
			d = 25'(BODY_COUNT) << k;
			if (r >= d) r = r - d;
		end
		return r[IW-1:0];
	endfunction

	// unpack the operation beat
	assign cmd.op   = s_tuser;
	assign cmd.two  = s_tdata[16];
	assign cmd.fsel = s_tdata[19:17];
	assign cmd.wval = s_tdata[51:20];
	assign cmd.nx   = s_tdata[67:52];
	assign cmd.ny   = s_tdata[83:68];
	assign cmd.pen  = s_tdata[115:84];
	assign cmd.rest = s_tdata[131:116];
	assign idx_a    = wrap_idx(s_tdata[7:0]);
	assign idx_b    = wrap_idx(s_tdata[15:8]);

	// one operation in flight at a time
	assign s_tready = idle;

	cir_core #(
		.DEPTH     (BODY_COUNT),
		.IW        (IW),
		.FRAC_BITS (FRACTION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid && idle),
		.cmd       (cmd),
		.idx_a     (idx_a),
		.idx_b     (idx_b),
		.time_step (time_step_q),
		.idle      (idle),
		.res       (res),
		.res_ready (res_ready)
	);

	// output register between core and result channel
	assign res_ready = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			m_tdata_q <= {6'd0, res.impulsed, res.moved, res.read_value};
		end
	end

	// configuration register, written in the apb access phase
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIME_STEP) ? {1'b0, time_step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= 31'd1092;
		end else if (psel && penable && pwrite && paddr[2] == REG_TIME_STEP) begin
			time_step_q <= pwdata[30:0];
		end
	end

endmodule
